// File: hw/rtl/ufp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
// Holds the result layout, phase and kind codes, and the CRC-16 byte update.
// No dependencies.
`default_nettype none

package ufp_pkg;

  localparam int unsigned HdrLen = 6;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;
  localparam logic [15:0] CrcInit = 16'h0000;
  localparam logic [15:0] MaxPayloadRst = 16'd4096;
  localparam logic [15:0] IdleLimitRst  = 16'd50;

  // Configuration register indexes.
  localparam logic CfgMaxPayload = 1'b0;
  localparam logic CfgIdleLimit  = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_OVERSIZE = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'b001,
    PH_PAYLOAD  = 3'b010,
    PH_CHECKSUM = 3'b100
  } phase_e;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [15:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_id;
    logic [15:0] frame_len;
    logic [7:0]  data_byte;
    logic        crc_ok;
    logic        last_byte;
  } res_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ufp_if.sv
// Valid/ready channel interfaces of the frame parser: byte/tick input and result output.
// Depends on ufp_pkg.
`default_nettype none

interface ufp_in_if ();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ufp_out_if import ufp_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_id;
  logic [15:0] frame_len;
  logic [7:0]  data_byte;
  logic        crc_ok;
  logic        last_byte;

  modport source (output valid, output kind, output frame_type, output frame_id,
                  output frame_len, output data_byte, output crc_ok,
                  output last_byte, input ready);
  modport sink   (input valid, input kind, input frame_type, input frame_id,
                  input frame_len, input data_byte, input crc_ok,
                  input last_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/uart_frame_parser_crc16.sv
// Top level of the length-prefixed frame parser with CRC-16/XMODEM check.
// Depends on ufp_pkg, ufp_if, ufp_parser and ufp_outbuf.
//
//   Channel   Role    Carries
//   in_i      sink    cmd (byte or idle tick), rx_byte
//   out_o     source  kind, frame_type, frame_id, frame_len, data_byte, crc_ok, last_byte
//   cfg_*     write   max_payload (index 0), idle_limit (index 1)
//
// Each transfer on in_i is handled in the cycle it is accepted: the phase logic and the
// byte-wide CRC update sit between the parser state registers and the result register,
// so one item is taken per cycle while in_ready is high, and each result is registered.
// in_ready drops only while the skid entry is occupied, which takes a stall of out_o.
// Reset is asynchronous and active low; it clears the parser state, the header bytes and
// loads the register defaults (max_payload 4096, idle_limit 50).
`default_nettype none

module uart_frame_parser_crc16 import ufp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ufp_in_if.sink           in_i,
  ufp_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  logic fire;
  logic res_vld;
  res_t res;
  logic buf_ready;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= MaxPayloadRst;
      cfg_q.idle_limit  <= IdleLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxPayload: cfg_q.max_payload <= cfg_data_i;
        CfgIdleLimit:  cfg_q.idle_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An input transfer happens whenever the result buffer has room for one more result.
  assign in_i.ready = buf_ready;
  assign fire       = in_i.valid && buf_ready;

  ufp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (in_i.cmd),
    .rx_byte_i (in_i.rx_byte),
    .cfg_i     (cfg_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ufp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out         (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ufp_parser.sv
// Frame parser state: header capture, payload tagging, CRC tracking and idle timeout.
// Depends on ufp_pkg.
`default_nettype none

module ufp_parser import ufp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic       cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_vld_o,
  output res_t            res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [7:0]  hs_q [HdrLen];
  logic [7:0]  hs_d [HdrLen];
  logic [15:0] pcnt_q, pcnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cklow_q, cklow_d;
  logic        ckcnt_q, ckcnt_d;
  logic [15:0] idle_q, idle_d;

  logic [15:0] idle_inc;
  logic [15:0] cur_len;
  logic [15:0] len_lo;
  logic        len_hi_nz;
  logic [15:0] pcnt_inc;
  logic [15:0] crc_upd;
  logic        mid;

  assign cur_len   = {hs_q[3], hs_q[2]};
  assign len_lo    = {hs_q[3], hs_q[2]};
  assign len_hi_nz = (rx_byte_i != 8'h00) || (hs_q[4] != 8'h00);
  assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign pcnt_inc  = (pcnt_q == 16'hFFFF) ? pcnt_q : pcnt_q + 16'd1;
  assign crc_upd   = crc16_byte(crc_q, rx_byte_i);
  assign mid       = (phase_q != PH_HEADER) || (hcnt_q != 3'd0);

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    hs_d    = hs_q;
    pcnt_d  = pcnt_q;
    crc_d   = crc_q;
    cklow_d = cklow_q;
    ckcnt_d = ckcnt_q;
    idle_d  = idle_q;
    res_vld_o = 1'b0;
    res_o     = '0;

    if (fire_i) begin
      if (cmd_i) begin
        idle_d = idle_inc;
        if (mid && (idle_inc > cfg_i.idle_limit)) begin
          phase_d = PH_HEADER;
          hcnt_d  = 3'd0;
          pcnt_d  = 16'd0;
          crc_d   = CrcInit;
          cklow_d = 8'h00;
          ckcnt_d = 1'b0;
          res_vld_o  = 1'b1;
          res_o.kind = KIND_TIMEOUT;
        end
      end else begin
        idle_d = 16'd0;
        case (phase_q)
          PH_HEADER: begin
            if (hcnt_q > 3'(HdrLen - 1)) begin
              hcnt_d  = 3'd0;
              pcnt_d  = 16'd0;
              crc_d   = CrcInit;
              cklow_d = 8'h00;
              ckcnt_d = 1'b0;
            end else begin
              hs_d[hcnt_q] = rx_byte_i;
              if (hcnt_q < 3'd2) begin
                crc_d = crc_upd;
              end
              hcnt_d = hcnt_q + 3'd1;
              if (hcnt_q == 3'(HdrLen - 1)) begin
                hcnt_d = 3'd0;
                pcnt_d = 16'd0;
                if (len_hi_nz || (len_lo > cfg_i.max_payload)) begin
                  // Oversize header: report with the length saturated to 16 bits.
                  res_vld_o        = 1'b1;
                  res_o.kind       = KIND_OVERSIZE;
                  res_o.frame_type = hs_q[0];
                  res_o.frame_id   = hs_q[1];
                  res_o.frame_len  = len_hi_nz ? 16'hFFFF : len_lo;
                  phase_d = PH_HEADER;
                  crc_d   = CrcInit;
                  cklow_d = 8'h00;
                  ckcnt_d = 1'b0;
                end else if (!len_hi_nz && (len_lo == 16'd0)) begin
                  phase_d = PH_CHECKSUM;
                end else begin
                  phase_d = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            crc_d  = crc_upd;
            pcnt_d = pcnt_inc;
            if (pcnt_inc >= cur_len) begin
              phase_d = PH_CHECKSUM;
            end
            res_vld_o        = 1'b1;
            res_o.kind       = KIND_PAYLOAD;
            res_o.frame_type = hs_q[0];
            res_o.frame_id   = hs_q[1];
            res_o.frame_len  = cur_len;
            res_o.data_byte  = rx_byte_i;
            res_o.last_byte  = (pcnt_inc >= cur_len);
          end
          PH_CHECKSUM: begin
            if (!ckcnt_q) begin
              cklow_d = rx_byte_i;
              ckcnt_d = 1'b1;
            end else begin
              res_vld_o        = 1'b1;
              res_o.kind       = KIND_FRAME;
              res_o.frame_type = hs_q[0];
              res_o.frame_id   = hs_q[1];
              res_o.frame_len  = cur_len;
              res_o.crc_ok     = ({rx_byte_i, cklow_q} == crc_q);
              phase_d = PH_HEADER;
              hcnt_d  = 3'd0;
              pcnt_d  = 16'd0;
              crc_d   = CrcInit;
              cklow_d = 8'h00;
              ckcnt_d = 1'b0;
            end
          end
          default: begin
            phase_d = PH_HEADER;
            hcnt_d  = 3'd0;
            pcnt_d  = 16'd0;
            crc_d   = CrcInit;
            cklow_d = 8'h00;
            ckcnt_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= 3'd0;
      for (int i = 0; i < HdrLen; i++) begin
        hs_q[i] <= 8'h00;
      end
      pcnt_q  <= 16'd0;
      crc_q   <= CrcInit;
      cklow_q <= 8'h00;
      ckcnt_q <= 1'b0;
      idle_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hs_q    <= hs_d;
      pcnt_q  <= pcnt_d;
      crc_q   <= crc_d;
      cklow_q <= cklow_d;
      ckcnt_q <= ckcnt_d;
      idle_q  <= idle_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ufp_outbuf.sv
// Result register with one skid entry, so the parser keeps taking items while a
// result waits on the output channel. Depends on ufp_pkg and ufp_out_if.
`default_nettype none

module ufp_outbuf import ufp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire res_t  push_data_i,
  output logic       ready_o,
  ufp_out_if.source  out
);

  logic out_v_q, out_v_d;
  logic skid_v_q, skid_v_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop     = out_v_q && out.ready;
  assign ready_o = !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q || pop) begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out.valid      = out_v_q;
  assign out.kind       = out_q.kind;
  assign out.frame_type = out_q.frame_type;
  assign out.frame_id   = out_q.frame_id;
  assign out.frame_len  = out_q.frame_len;
  assign out.data_byte  = out_q.data_byte;
  assign out.crc_ok     = out_q.crc_ok;
  assign out.last_byte  = out_q.last_byte;

endmodule

`default_nettype wire
